@@ rtl/wtt_pkg.sv @@
// ============================================================================
// Welch t-test accumulator package
// Shared constants, codes and word types of the leakage accumulator.
// ============================================================================
package wtt_pkg;

    localparam int SAMPLES     = 1024;
    localparam int PT_W        = $clog2(SAMPLES);
    localparam int ADDR_W      = PT_W + 1;
    localparam int STAT_DEPTH  = 2 * SAMPLES;
    localparam int CMP_W       = 18;
    localparam int FRAC        = 18;
    localparam int MEAN_W      = 36;
    localparam int SPREAD_W    = 64;
    localparam int STAT_W      = MEAN_W + SPREAD_W;
    localparam int SAMPLE_W    = 16;
    localparam int PADDR_W     = 5;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2
    } wtt_cmd_e;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_CLEAR  = 2'd2
    } wtt_kind_e;

    typedef enum logic [2:0] {
        REG_FIRST_POINT = 3'd0,
        REG_END_POINT   = 3'd1,
        REG_TEST_ORDER  = 3'd2,
        REG_LAG_FIRST   = 3'd3,
        REG_LAG_SECOND  = 3'd4,
        REG_LAG_THIRD   = 3'd5,
        REG_THRESHOLD   = 3'd6
    } wtt_reg_e;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } wtt_op_e;

    typedef struct packed {
        logic [1:0]                 cmd;
        logic                       group;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       end_of_trace;
        logic [9:0]                 query_point;
    } wtt_in_t;

    typedef struct packed {
        logic signed [31:0] t_value;
        logic               exceeds;
        logic               undefined;
        logic [9:0]         point;
    } wtt_out_t;

    typedef struct packed {
        wtt_kind_e                  kind;
        logic                       group;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       end_of_trace;
        logic [9:0]                 query_point;
    } wtt_job_t;

    typedef struct packed {
        logic [9:0]  first_point;
        logic [10:0] end_point;
        logic [2:0]  test_order;
        logic [9:0]  lag_first;
        logic [9:0]  lag_second;
        logic [9:0]  lag_third;
        logic [30:0] threshold;
    } wtt_cfg_t;

    typedef struct packed {
        wtt_op_e      op;
        logic [127:0] a;
        logic [63:0]  b;
        logic [7:0]   iters;
    } wtt_math_req_t;

endpackage

@@ rtl/wtt_ram.sv @@
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module wtt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/wtt_math.sv @@
// ============================================================================
// Shared arithmetic unit
// Iterative shift-add multiplier, restoring divider and square root.
// ============================================================================
module wtt_math (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  wtt_pkg::wtt_math_req_t req,
    output logic                   done,
    output logic [127:0]           res
);

    import wtt_pkg::*;

    typedef enum logic {
        M_IDLE,
        M_RUN
    } state_t;

    state_t       state_reg;
    wtt_op_e      op_reg;
    logic [127:0] x_reg;
    logic [63:0]  y_reg;
    logic [127:0] acc_reg;
    logic [66:0]  r_reg;
    logic [7:0]   cnt_reg;
    logic         done_reg;

    logic [64:0]  div_rr;
    logic         div_ge;
    logic [66:0]  sq_rr;
    logic [66:0]  sq_trial;
    logic         sq_ge;

    always_comb
    begin
        div_rr   = {r_reg[63:0], x_reg[127]};
        div_ge   = div_rr >= {1'b0, y_reg};
        sq_rr    = {r_reg[64:0], x_reg[127:126]};
        sq_trial = {1'b0, acc_reg[63:0], 2'b01};
        sq_ge    = sq_rr >= sq_trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            op_reg    <= OP_MUL;
            x_reg     <= '0;
            y_reg     <= '0;
            acc_reg   <= '0;
            r_reg     <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= req.op;
                        x_reg     <= req.a;
                        y_reg     <= req.b;
                        acc_reg   <= '0;
                        r_reg     <= '0;
                        cnt_reg   <= req.iters;
                        state_reg <= M_RUN;
                    end
                end
                M_RUN:
                begin
                    case (op_reg)
                        OP_MUL:
                        begin
                            if (y_reg[0])
                            begin
                                acc_reg <= acc_reg + x_reg;
                            end
                            x_reg <= {x_reg[126:0], 1'b0};
                            y_reg <= {1'b0, y_reg[63:1]};
                        end
                        OP_DIV:
                        begin
                            if (div_ge)
                            begin
                                r_reg <= {2'b0, div_rr - {1'b0, y_reg}};
                            end
                            else
                            begin
                                r_reg <= {2'b0, div_rr};
                            end
                            acc_reg <= {acc_reg[126:0], div_ge};
                            x_reg   <= {x_reg[126:0], 1'b0};
                        end
                        OP_SQRT:
                        begin
                            if (sq_ge)
                            begin
                                r_reg <= sq_rr - sq_trial;
                            end
                            else
                            begin
                                r_reg <= sq_rr;
                            end
                            acc_reg <= {acc_reg[126:0], sq_ge};
                            x_reg   <= {x_reg[125:0], 2'b00};
                        end
                        default:
                        begin
                            acc_reg <= acc_reg;
                        end
                    endcase
                    cnt_reg <= cnt_reg - 8'd1;
                    if (cnt_reg == 8'd1)
                    begin
                        state_reg <= M_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign res  = acc_reg;

endmodule

@@ rtl/wtt_front.sv @@
// ============================================================================
// Accumulator front end
// Register port, command decode and a two-word queue toward the back end.
// ============================================================================
module wtt_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  wtt_pkg::wtt_in_t           item,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wtt_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output wtt_pkg::wtt_cfg_t          cfg,
    output logic                       job_valid,
    output wtt_pkg::wtt_job_t          job,
    input  logic                       pop
);

    import wtt_pkg::*;

    wtt_cfg_t   cfg_reg;
    wtt_job_t   q_mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    logic       accept;
    logic       push;
    wtt_job_t   word;
    logic       cfg_we;
    wtt_reg_e   reg_idx;

    assign busy    = count_reg == 2'd2;
    assign accept  = start && !busy;
    assign cfg_we  = psel && penable && pwrite;
    assign reg_idx = wtt_reg_e'(paddr[PADDR_W-1:2]);
    assign pready  = 1'b1;

    always_comb
    begin
        word.group        = item.group;
        word.sample       = item.sample;
        word.end_of_trace = item.end_of_trace;
        word.query_point  = item.query_point;
        word.kind         = KIND_SAMPLE;
        push              = accept;
        case (item.cmd)
            CMD_SAMPLE: word.kind = KIND_SAMPLE;
            CMD_QUERY:  word.kind = KIND_QUERY;
            CMD_CLEAR:  word.kind = KIND_CLEAR;
            default:    push = 1'b0;
        endcase
    end

    always_comb
    begin
        case (reg_idx)
            REG_FIRST_POINT: prdata = {22'b0, cfg_reg.first_point};
            REG_END_POINT:   prdata = {21'b0, cfg_reg.end_point};
            REG_TEST_ORDER:  prdata = {29'b0, cfg_reg.test_order};
            REG_LAG_FIRST:   prdata = {22'b0, cfg_reg.lag_first};
            REG_LAG_SECOND:  prdata = {22'b0, cfg_reg.lag_second};
            REG_LAG_THIRD:   prdata = {22'b0, cfg_reg.lag_third};
            REG_THRESHOLD:   prdata = {1'b0, cfg_reg.threshold};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_point <= 10'd0;
            cfg_reg.end_point   <= 11'd1024;
            cfg_reg.test_order  <= 3'd1;
            cfg_reg.lag_first   <= 10'd1;
            cfg_reg.lag_second  <= 10'd1;
            cfg_reg.lag_third   <= 10'd1;
            cfg_reg.threshold   <= 31'd294912;
            q_mem_reg[0]        <= '0;
            q_mem_reg[1]        <= '0;
            wr_ptr_reg          <= 1'b0;
            rd_ptr_reg          <= 1'b0;
            count_reg           <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_idx)
                    REG_FIRST_POINT: cfg_reg.first_point <= pwdata[9:0];
                    REG_END_POINT:   cfg_reg.end_point   <= pwdata[10:0];
                    REG_TEST_ORDER:  cfg_reg.test_order  <= pwdata[2:0];
                    REG_LAG_FIRST:   cfg_reg.lag_first   <= pwdata[9:0];
                    REG_LAG_SECOND:  cfg_reg.lag_second  <= pwdata[9:0];
                    REG_LAG_THIRD:   cfg_reg.lag_third   <= pwdata[9:0];
                    REG_THRESHOLD:   cfg_reg.threshold   <= pwdata[30:0];
                    default:         cfg_reg.threshold   <= cfg_reg.threshold;
                endcase
            end
            if (push)
            begin
                q_mem_reg[wr_ptr_reg] <= word;
                wr_ptr_reg            <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign cfg       = cfg_reg;
    assign job_valid = count_reg != 2'd0;
    assign job       = q_mem_reg[rd_ptr_reg];

endmodule

@@ rtl/wtt_back.sv @@
// ============================================================================
// Accumulator back end
// Sequencer for lagged differences, Welford updates, queries and clearing.
// ============================================================================
module wtt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  wtt_pkg::wtt_cfg_t cfg,
    input  logic              job_valid,
    input  wtt_pkg::wtt_job_t job,
    output logic              pop,
    output logic              done,
    output wtt_pkg::wtt_out_t result
);

    import wtt_pkg::*;

    localparam logic [7:0] ITER_MEAN  = 8'd38;
    localparam logic [7:0] ITER_SPRD  = 8'd38;
    localparam logic [7:0] ITER_COUNT = 8'd32;
    localparam logic [7:0] ITER_VAR   = 8'd82;
    localparam logic [7:0] ITER_ROOT  = 8'd64;
    localparam logic [7:0] ITER_T     = 8'd69;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LAG,
        S_LAGD,
        S_STAT,
        S_DIV,
        S_MUL,
        S_QRD0,
        S_QRD1,
        S_QRD2,
        S_NN,
        S_WDIV,
        S_SQRT,
        S_TDIV
    } state_t;

    state_t                    state_reg;
    logic [ADDR_W-1:0]         clr_idx_reg;
    logic [PT_W-1:0]           pos_reg;
    logic [31:0]               cnt_reg [2];
    logic [1:0]                lag_idx_reg;
    wtt_job_t                  job_reg;
    logic signed [18:0]        x_reg;
    logic [ADDR_W-1:0]         k_reg;
    logic [32:0]               n_reg;
    logic signed [MEAN_W-1:0]  mean_reg;
    logic [SPREAD_W-1:0]       sp_reg;
    logic signed [37:0]        delta_reg;
    logic signed [MEAN_W-1:0]  m0_reg;
    logic signed [MEAN_W-1:0]  m1_reg;
    logic [SPREAD_W-1:0]       sp0_reg;
    logic [SPREAD_W-1:0]       sp1_reg;
    logic [82:0]               w_reg;
    logic                      grp_reg;
    logic                      math_start_reg;
    wtt_math_req_t             math_req_reg;
    logic                      done_reg;
    wtt_out_t                  result_reg;

    logic                      math_done;
    logic [127:0]              math_res;

    logic                      line_we;
    logic [PT_W-1:0]           line_raddr;
    logic [SAMPLE_W-1:0]       line_rdata;
    logic                      stat_we;
    logic [ADDR_W-1:0]         stat_waddr;
    logic [STAT_W-1:0]         stat_wdata;
    logic [ADDR_W-1:0]         stat_raddr;
    logic [STAT_W-1:0]         stat_rdata;

    logic [1:0]                nlags;
    logic [9:0]                lag_sel;
    logic [CMP_W-1:0]          pos_ext;
    logic [CMP_W-1:0]          lag_ext;
    logic [CMP_W-1:0]          lag_diff;
    logic                      lag_past;
    logic                      lag_zero;
    logic                      lags_done;
    logic                      in_window;
    logic [ADDR_W-1:0]         sample_addr;
    logic [CMP_W-1:0]          pt_ext;
    logic                      pt_in;
    logic [PT_W-1:0]           pt_addr;
    logic signed [18:0]        sample_ext;
    logic signed [18:0]        line_ext;

    logic signed [37:0]        xs_c;
    logic signed [MEAN_W-1:0]  mean_rd_c;
    logic [SPREAD_W-1:0]       sp_rd_c;
    logic signed [37:0]        delta_c;
    logic [37:0]               dmag_rd_c;
    logic [37:0]               dmag_c;
    logic [37:0]               qsig_c;
    logic signed [37:0]        newmean_c;
    logic signed [37:0]        e_c;
    logic [37:0]               emag_c;
    logic [64:0]               sum_c;
    logic [SPREAD_W-1:0]       spsat_c;
    logic [SPREAD_W-1:0]       sp_sel_c;
    logic [82:0]               w_c;
    logic signed [36:0]        d_c;
    logic [36:0]               dm_c;
    logic [31:0]               lim_c;
    logic [31:0]               tm_c;
    logic [31:0]               t_c;
    logic                      undef_c;

    always_comb
    begin
        if (cfg.test_order < 3'd2)
        begin
            nlags = 2'd0;
        end
        else if (cfg.test_order == 3'd2)
        begin
            nlags = 2'd1;
        end
        else if (cfg.test_order == 3'd3)
        begin
            nlags = 2'd2;
        end
        else
        begin
            nlags = 2'd3;
        end
        case (lag_idx_reg)
            2'd0:    lag_sel = cfg.lag_first;
            2'd1:    lag_sel = cfg.lag_second;
            default: lag_sel = cfg.lag_third;
        endcase
        pos_ext     = CMP_W'(pos_reg);
        lag_ext     = CMP_W'(lag_sel);
        lag_diff    = pos_ext - lag_ext;
        lag_past    = lag_ext > pos_ext;
        lag_zero    = lag_sel == 10'd0;
        lags_done   = lag_idx_reg >= nlags;
        in_window   = (pos_ext >= CMP_W'(cfg.first_point)) && (pos_ext < CMP_W'(cfg.end_point));
        sample_addr = {job_reg.group, pos_reg};
        pt_ext      = CMP_W'(job_reg.query_point);
        pt_in       = pt_ext < CMP_W'(SAMPLES);
        pt_addr     = pt_ext[PT_W-1:0];
        sample_ext  = {{3{job_reg.sample[SAMPLE_W-1]}}, job_reg.sample};
        line_ext    = {{3{line_rdata[SAMPLE_W-1]}}, line_rdata};
    end

    always_comb
    begin
        xs_c      = {x_reg[18], x_reg, 18'b0};
        mean_rd_c = stat_rdata[STAT_W-1:SPREAD_W];
        sp_rd_c   = stat_rdata[SPREAD_W-1:0];
        delta_c   = xs_c - {{2{mean_rd_c[MEAN_W-1]}}, mean_rd_c};
        dmag_rd_c = delta_c[37] ? (~delta_c + 38'd1) : delta_c;
        dmag_c    = delta_reg[37] ? (~delta_reg + 38'd1) : delta_reg;
        qsig_c    = delta_reg[37] ? (~math_res[37:0] + 38'd1) : math_res[37:0];
        newmean_c = {{2{mean_reg[MEAN_W-1]}}, mean_reg} + qsig_c;
        e_c       = xs_c - newmean_c;
        emag_c    = e_c[37] ? (~e_c + 38'd1) : e_c;
        sum_c     = {1'b0, sp_reg} + {3'b0, math_res[79:FRAC]};
        spsat_c   = sum_c[64] ? {SPREAD_W{1'b1}} : sum_c[63:0];
        sp_sel_c  = grp_reg ? sp1_reg : sp0_reg;
        w_c       = w_reg + {1'b0, math_res[81:0]};
        d_c       = {m0_reg[MEAN_W-1], m0_reg} - {m1_reg[MEAN_W-1], m1_reg};
        dm_c      = d_c[36] ? (~d_c + 37'd1) : d_c;
        lim_c     = d_c[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        tm_c      = (math_res[68:0] > {37'b0, lim_c}) ? lim_c : math_res[31:0];
        t_c       = d_c[36] ? (~tm_c + 32'd1) : tm_c;
        undef_c   = (cnt_reg[0] < 32'd2) || (cnt_reg[1] < 32'd2);
    end

    always_comb
    begin
        pop        = (state_reg == S_IDLE) && job_valid;
        line_we    = (state_reg == S_LAG) && lags_done;
        line_raddr = lag_diff[PT_W-1:0];
        case (state_reg)
            S_QRD0:  stat_raddr = {1'b0, pt_addr};
            S_QRD1:  stat_raddr = {1'b1, pt_addr};
            default: stat_raddr = sample_addr;
        endcase
        stat_we    = (state_reg == S_CLEAR) || ((state_reg == S_MUL) && math_done);
        stat_waddr = (state_reg == S_CLEAR) ? clr_idx_reg : k_reg;
        stat_wdata = (state_reg == S_CLEAR) ? '0 : {mean_reg, spsat_c};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            pos_reg        <= '0;
            cnt_reg[0]     <= '0;
            cnt_reg[1]     <= '0;
            lag_idx_reg    <= '0;
            job_reg        <= '0;
            x_reg          <= '0;
            k_reg          <= '0;
            n_reg          <= '0;
            mean_reg       <= '0;
            sp_reg         <= '0;
            delta_reg      <= '0;
            m0_reg         <= '0;
            m1_reg         <= '0;
            sp0_reg        <= '0;
            sp1_reg        <= '0;
            w_reg          <= '0;
            grp_reg        <= 1'b0;
            math_start_reg <= 1'b0;
            math_req_reg   <= '0;
            done_reg       <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            math_start_reg <= 1'b0;
            done_reg       <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == ADDR_W'(STAT_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg <= job;
                        case (job.kind)
                            KIND_SAMPLE:
                            begin
                                x_reg       <= {{3{job.sample[SAMPLE_W-1]}}, job.sample};
                                lag_idx_reg <= '0;
                                state_reg   <= S_LAG;
                            end
                            KIND_QUERY:
                            begin
                                state_reg <= S_QRD0;
                            end
                            KIND_CLEAR:
                            begin
                                clr_idx_reg <= '0;
                                cnt_reg[0]  <= '0;
                                cnt_reg[1]  <= '0;
                                pos_reg     <= '0;
                                state_reg   <= S_CLEAR;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_LAG:
                begin
                    if (lags_done)
                    begin
                        k_reg <= sample_addr;
                        n_reg <= {1'b0, cnt_reg[job_reg.group]} + 33'd1;
                        if (job_reg.end_of_trace)
                        begin
                            pos_reg <= '0;
                            if (cnt_reg[job_reg.group] != 32'hFFFF_FFFF)
                            begin
                                cnt_reg[job_reg.group] <= cnt_reg[job_reg.group] + 32'd1;
                            end
                        end
                        else if (pos_reg == PT_W'(SAMPLES - 1))
                        begin
                            pos_reg <= '0;
                        end
                        else
                        begin
                            pos_reg <= pos_reg + 1'b1;
                        end
                        state_reg <= in_window ? S_STAT : S_IDLE;
                    end
                    else if (lag_past)
                    begin
                        lag_idx_reg <= lag_idx_reg + 2'd1;
                    end
                    else if (lag_zero)
                    begin
                        x_reg       <= x_reg - sample_ext;
                        lag_idx_reg <= lag_idx_reg + 2'd1;
                    end
                    else
                    begin
                        state_reg <= S_LAGD;
                    end
                end
                S_LAGD:
                begin
                    x_reg       <= x_reg - line_ext;
                    lag_idx_reg <= lag_idx_reg + 2'd1;
                    state_reg   <= S_LAG;
                end
                S_STAT:
                begin
                    mean_reg       <= mean_rd_c;
                    sp_reg         <= sp_rd_c;
                    delta_reg      <= delta_c;
                    math_start_reg <= 1'b1;
                    math_req_reg   <= '{op: OP_DIV, a: {dmag_rd_c, 90'b0},
                                        b: {31'b0, n_reg}, iters: ITER_MEAN};
                    state_reg      <= S_DIV;
                end
                S_DIV:
                begin
                    if (math_done)
                    begin
                        mean_reg       <= newmean_c[MEAN_W-1:0];
                        math_start_reg <= 1'b1;
                        math_req_reg   <= '{op: OP_MUL, a: {90'b0, dmag_c},
                                            b: {26'b0, emag_c}, iters: ITER_SPRD};
                        state_reg      <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (math_done)
                    begin
                        sp_reg    <= spsat_c;
                        state_reg <= S_IDLE;
                    end
                end
                S_QRD0:
                begin
                    state_reg <= S_QRD1;
                end
                S_QRD1:
                begin
                    m0_reg    <= pt_in ? mean_rd_c : '0;
                    sp0_reg   <= pt_in ? sp_rd_c : '0;
                    state_reg <= S_QRD2;
                end
                S_QRD2:
                begin
                    m1_reg  <= pt_in ? mean_rd_c : '0;
                    sp1_reg <= pt_in ? sp_rd_c : '0;
                    if (undef_c)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '{t_value: '0, exceeds: 1'b0, undefined: 1'b1,
                                        point: job_reg.query_point};
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        grp_reg        <= 1'b0;
                        w_reg          <= '0;
                        math_start_reg <= 1'b1;
                        math_req_reg   <= '{op: OP_MUL, a: {96'b0, cnt_reg[0]},
                                            b: {32'b0, cnt_reg[0] - 32'd1},
                                            iters: ITER_COUNT};
                        state_reg      <= S_NN;
                    end
                end
                S_NN:
                begin
                    if (math_done)
                    begin
                        math_start_reg <= 1'b1;
                        math_req_reg   <= '{op: OP_DIV, a: {sp_sel_c, 64'b0},
                                            b: math_res[63:0], iters: ITER_VAR};
                        state_reg      <= S_WDIV;
                    end
                end
                S_WDIV:
                begin
                    if (math_done)
                    begin
                        w_reg <= w_c;
                        if (!grp_reg)
                        begin
                            grp_reg        <= 1'b1;
                            math_start_reg <= 1'b1;
                            math_req_reg   <= '{op: OP_MUL, a: {96'b0, cnt_reg[1]},
                                                b: {32'b0, cnt_reg[1] - 32'd1},
                                                iters: ITER_COUNT};
                            state_reg      <= S_NN;
                        end
                        else if (w_c == '0)
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '{t_value: '0, exceeds: 1'b0, undefined: 1'b1,
                                            point: job_reg.query_point};
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            math_start_reg <= 1'b1;
                            math_req_reg   <= '{op: OP_SQRT, a: {13'b0, w_c, 32'b0},
                                                b: '0, iters: ITER_ROOT};
                            state_reg      <= S_SQRT;
                        end
                    end
                end
                S_SQRT:
                begin
                    if (math_done)
                    begin
                        math_start_reg <= 1'b1;
                        math_req_reg   <= '{op: OP_DIV, a: {dm_c, 91'b0},
                                            b: math_res[63:0], iters: ITER_T};
                        state_reg      <= S_TDIV;
                    end
                end
                S_TDIV:
                begin
                    if (math_done)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '{t_value: t_c, exceeds: tm_c > {1'b0, cfg.threshold},
                                        undefined: 1'b0, point: job_reg.query_point};
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    wtt_math u_math (
        .clk   (clk),
        .rst_n (rst_n),
        .start (math_start_reg),
        .req   (math_req_reg),
        .done  (math_done),
        .res   (math_res)
    );

    wtt_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (SAMPLES)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (pos_reg),
        .wdata (job_reg.sample),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    wtt_ram #(
        .WIDTH (STAT_W),
        .DEPTH (STAT_DEPTH)
    ) u_stat_ram (
        .clk   (clk),
        .we    (stat_we),
        .waddr (stat_waddr),
        .wdata (stat_wdata),
        .raddr (stat_raddr),
        .rdata (stat_rdata)
    );

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ rtl/welch_t_test_leakage_accumulator.sv @@
// ============================================================================
// Welch t-test leakage accumulator
// Online per-point Welford statistics of two trace groups with t queries.
// ============================================================================
// A word is offered on item with start and is taken at a clock edge where
// start is high and busy is low. Commands are trace samples, t queries at a
// point and a clear of all statistics; a word with an unused command is
// taken and dropped. Only a query answers, with one result word shown for a
// single cycle while done is high; the receiver has no way to hold it off.
// The front end buffers up to two words, and busy rises when both are held.
// Once a word leaves the queue, a sample is worked through one configured
// lag at a time, with an extra state for a lag read from the line memory,
// and one inside the window then runs the 38-step iterative divide and
// multiply of the Welford update. A query on too few traces answers right
// after both groups' statistics are read; any other runs, one after another
// on the shared iterative unit, two count products, two 82-step divides and,
// unless the variance sum is zero, a 64-step square root and a 69-step divide.
// After reset and after a clear command all 2048 statistics entries are
// cleared one entry per cycle; words queue in the meantime, and
// configuration writes are taken at any time over the register port.
// ============================================================================
module welch_t_test_leakage_accumulator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  wtt_pkg::wtt_in_t            item,
    output logic                        done,
    output wtt_pkg::wtt_out_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wtt_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    import wtt_pkg::*;

    wtt_cfg_t cfg;
    logic     job_valid;
    wtt_job_t job;
    logic     pop;

    wtt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .job_valid (job_valid),
        .job       (job),
        .pop       (pop)
    );

    wtt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (job_valid),
        .job       (job),
        .pop       (pop),
        .done      (done),
        .result    (result)
    );

endmodule

@@ rtl/wtt_checker.sv @@
// ============================================================================
// Accumulator port checker
// Checks result words and the register port as seen on the top level.
// ============================================================================
module wtt_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              done,
    input wtt_pkg::wtt_out_t result,
    input logic              pready
);

    import wtt_pkg::*;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Two result words in consecutive cycles.");

    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.undefined) |-> (result.t_value == 32'sd0 && !result.exceeds))
        else $error("Undefined result carries a t value or a flag.");

    a_exceeds_defined: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.exceeds) |-> (result.t_value != 32'sd0 && !result.undefined))
        else $error("Threshold flag on a zero or undefined t value.");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("Register port stalled.");

endmodule

bind welch_t_test_leakage_accumulator wtt_checker u_wtt_checker (.*);

@@ dv/wtt_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Welch t-test accumulator checker
// Watches the command, result and register channels, keeps its own copy of
// the per-point Welford statistics and compares every query answer.
// ============================================================================
module wtt_predictor
    import wtt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  wtt_in_t             item,
    input  logic                done,
    input  wtt_out_t            result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    output int                  pending,
    output int                  errors
);

    logic [9:0]  c_first;
    logic [10:0] c_end;
    logic [2:0]  c_order;
    logic [9:0]  c_lag1;
    logic [9:0]  c_lag2;
    logic [9:0]  c_lag3;
    logic [30:0] c_thresh;

    logic [15:0] line_mem [SAMPLES];
    int unsigned pos;
    bit [31:0]   traces [2];
    longint      mean_mem [STAT_DEPTH];
    bit [63:0]   spread_mem [STAT_DEPTH];

    wtt_out_t    answers [$];

    function automatic bit [63:0] magn(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint lag_tap(int unsigned lag, int unsigned p, longint cur);
        if (lag > p)
            return 0;
        if (lag == 0)
            return cur;
        return longint'($signed(line_mem[p - lag]));
    endfunction

    function automatic bit [63:0] root128(bit [127:0] a);
        bit [63:0]  r;
        bit [63:0]  c;
        bit [127:0] cc;
        r = 0;
        for (int i = 62; i >= 0; i--)
        begin
            c = r | (64'd1 << i);
            cc = {64'd0, c} * {64'd0, c};
            if (cc <= a)
                r = c;
        end
        return r;
    endfunction

    task automatic accumulate(bit g, logic signed [15:0] s, bit last);
        int unsigned ord;
        int unsigned endp;
        int unsigned k;
        longint      x;
        longint      xs;
        longint      delta;
        longint      q;
        bit [63:0]   n;
        bit [63:0]   qm;
        bit [127:0]  prod;
        bit [63:0]   inc;
        bit [63:0]   sum;
        ord = c_order;
        endp = c_end > SAMPLES ? SAMPLES : c_end;
        x = s;
        if (ord >= 2)
            x -= lag_tap(c_lag1, pos, s);
        if (ord >= 3)
            x -= lag_tap(c_lag2, pos, s);
        if (ord >= 4)
            x -= lag_tap(c_lag3, pos, s);
        line_mem[pos] = s;
        if (pos >= c_first && pos < endp)
        begin
            k = g * SAMPLES + pos;
            n = 64'(traces[g]) + 1;
            xs = x * (64'sd1 <<< FRAC);
            delta = xs - mean_mem[k];
            qm = magn(delta) / n;
            q = delta < 0 ? -longint'(qm) : longint'(qm);
            mean_mem[k] += q;
            prod = {64'd0, magn(delta)} * {64'd0, magn(xs - mean_mem[k])};
            inc = 64'(prod >> FRAC);
            sum = spread_mem[k] + inc;
            spread_mem[k] = sum < inc ? '1 : sum;
        end
        if (last)
        begin
            pos = 0;
            if (traces[g] != 32'hFFFF_FFFF)
                traces[g]++;
        end
        else
            pos = (pos + 1) % SAMPLES;
    endtask

    function automatic wtt_out_t t_stat(logic [9:0] p);
        wtt_out_t   o;
        bit [127:0] w;
        bit [63:0]  n;
        bit [63:0]  r;
        bit [63:0]  tm;
        bit [63:0]  lim;
        bit [127:0] qt;
        longint     d;
        o.t_value = 0;
        o.exceeds = 0;
        o.undefined = 1;
        o.point = p;
        if (traces[0] < 2 || traces[1] < 2)
            return o;
        w = 0;
        for (int g = 0; g < 2; g++)
        begin
            n = traces[g];
            w += ({64'd0, spread_mem[g * SAMPLES + p]} << FRAC) / {64'd0, n * (n - 1)};
        end
        if (w == 0)
            return o;
        r = root128(w << 32);
        d = mean_mem[p] - mean_mem[SAMPLES + p];
        qt = ({64'd0, magn(d)} << 32) / {64'd0, r};
        lim = d < 0 ? 64'h8000_0000 : 64'h7FFF_FFFF;
        tm = qt > {64'd0, lim} ? lim : qt[63:0];
        o.t_value = d < 0 ? 32'(-tm) : 32'(tm);
        o.exceeds = tm > c_thresh;
        o.undefined = 0;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_first = 0;
            c_end = 1024;
            c_order = 1;
            c_lag1 = 1;
            c_lag2 = 1;
            c_lag3 = 1;
            c_thresh = 294912;
            pos = 0;
            traces[0] = 0;
            traces[1] = 0;
            foreach (mean_mem[i])
            begin
                mean_mem[i] = 0;
                spread_mem[i] = 0;
            end
            errors = 0;
            answers.delete();
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (answers.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word %h", $time, result);
                end
                else
                begin
                    wtt_out_t want;
                    want = answers.pop_front();
                    if (want.t_value !== result.t_value)
                        $display("%0t: t_value expected %0d actual %0d", $time,
                                 want.t_value, result.t_value);
                    if (want.exceeds !== result.exceeds)
                        $display("%0t: exceeds expected %0b actual %0b", $time,
                                 want.exceeds, result.exceeds);
                    if (want.undefined !== result.undefined)
                        $display("%0t: undefined expected %0b actual %0b", $time,
                                 want.undefined, result.undefined);
                    if (want.point !== result.point)
                        $display("%0t: point expected %0d actual %0d", $time,
                                 want.point, result.point);
                    if (want !== result)
                        errors++;
                end
            end
            if (start && !busy)
            begin
                case (item.cmd)
                    CMD_SAMPLE:
                        accumulate(item.group, item.sample, item.end_of_trace);
                    CMD_QUERY:
                        answers.insert(answers.size(), t_stat(item.query_point));
                    CMD_CLEAR:
                    begin
                        foreach (mean_mem[i])
                        begin
                            mean_mem[i] = 0;
                            spread_mem[i] = 0;
                        end
                        traces[0] = 0;
                        traces[1] = 0;
                        pos = 0;
                    end
                    default: ;
                endcase
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_FIRST_POINT: c_first = pwdata[9:0];
                    REG_END_POINT:   c_end = pwdata[10:0];
                    REG_TEST_ORDER:  c_order = pwdata[2:0];
                    REG_LAG_FIRST:   c_lag1 = pwdata[9:0];
                    REG_LAG_SECOND:  c_lag2 = pwdata[9:0];
                    REG_LAG_THIRD:   c_lag3 = pwdata[9:0];
                    REG_THRESHOLD:   c_thresh = pwdata[30:0];
                    default: ;
                endcase
            end
            pending = answers.size();
        end
    end

endmodule

@@ dv/tb_welch_t_test_leakage_accumulator.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Welch t-test accumulator testbench
// Streams short two-group traces, queries and clears through the command
// port under several register settings; a checker predicts every answer.
// ============================================================================
module tb_welch_t_test_leakage_accumulator;
    import wtt_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int WATCHDOG = 20000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    wtt_in_t            item;
    logic               done;
    wtt_out_t           result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 pending;
    int                 errors;
    int                 quiet;
    int                 idle_pct;
    int                 tpos;
    int                 tlen;
    bit                 tgroup;

    welch_t_test_leakage_accumulator dut (.*);

    wtt_predictor u_predictor (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > WATCHDOG)
        begin
            $display("welch_t_test_leakage_accumulator: mismatch");
            $finish;
        end
    end

    task automatic send_word(logic [1:0] c, bit g, logic [15:0] s, bit eot, logic [9:0] qp);
        bit b;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1;
        item <= '{cmd: c, group: g, sample: s, end_of_trace: eot, query_point: qp};
        do
        begin
            @(negedge clk);
            b = busy;
            @(posedge clk);
        end
        while (b);
    endtask

    task automatic settle();
        start <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2300) @(posedge clk);
    endtask

    task automatic write_reg(wtt_reg_e r, logic [31:0] v);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= PADDR_W'(r) << 2;
        pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        @(posedge clk);
    endtask

    task automatic configure(int ph);
        logic [9:0]  fp;
        logic [10:0] ep;
        logic [30:0] th;
        fp = $urandom_range(0, 3);
        ep = $urandom_range(4, 16);
        th = $urandom_range(0, 20) << 16;
        if (ph == 1)
        begin
            fp = 0;
            ep = 11'h7FF;
            th = 0;
        end
        if (ph == 2)
        begin
            ep = 0;
            th = 31'h7FFF_FFFF;
        end
        if (ph == 5)
        begin
            fp = 10'h3FF;
            ep = 1024;
        end
        write_reg(REG_FIRST_POINT, fp);
        write_reg(REG_END_POINT, ep);
        write_reg(REG_TEST_ORDER, ph == 1 ? 0 : ph == 2 ? 7 : $urandom_range(1, 4));
        write_reg(REG_LAG_FIRST, ph == 3 ? 10'h3FF : $urandom_range(0, 6));
        write_reg(REG_LAG_SECOND, ph == 3 ? 0 : $urandom_range(0, 6));
        write_reg(REG_LAG_THIRD, $urandom_range(0, 6));
        write_reg(REG_THRESHOLD, th);
    endtask

    task automatic trace_sample(logic [15:0] s);
        bit eot;
        if (tpos == 0)
        begin
            tlen = $urandom_range(3, 12);
            tgroup = $urandom_range(1);
        end
        eot = tpos == tlen - 1;
        send_word(CMD_SAMPLE, tgroup, s, eot, 10'($urandom));
        tpos = eot ? 0 : tpos + 1;
    endtask

    task automatic random_items(int count);
        int k;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(99);
            if (k < 82)
                trace_sample($urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 400)));
            else if (k < 96)
                send_word(CMD_QUERY, $urandom, 16'($urandom), $urandom,
                          $urandom_range(3) == 0 ? 10'($urandom) : 10'($urandom_range(15)));
            else if (k < 97)
            begin
                send_word(CMD_CLEAR, $urandom, 16'($urandom), $urandom, 10'($urandom));
                tpos = 0;
            end
            else if (k < 98)
                send_word(CMD_UNUSED, $urandom, 16'($urandom), $urandom, 10'($urandom));
            else
            begin
                start <= 0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
        end
    endtask

    initial
    begin
        rst_n = 0;
        start = 0;
        item = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        quiet = 0;
        idle_pct = 0;
        tpos = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        for (int t = 0; t < 4; t++)
        begin
            send_word(CMD_SAMPLE, t[0], 16'h8000, 0, 0);
            send_word(CMD_SAMPLE, t[0], 16'h7FFF, 0, 0);
            send_word(CMD_SAMPLE, t[0], 16'(t * 3), 1, 0);
        end
        send_word(CMD_QUERY, 0, 0, 0, 0);
        send_word(CMD_QUERY, 1, 16'hFFFF, 1, 2);
        send_word(CMD_QUERY, 0, 0, 0, 10'h3FF);
        send_word(CMD_UNUSED, 1, 16'hFFFF, 1, 10'h3FF);
        send_word(CMD_CLEAR, 0, 0, 0, 0);
        send_word(CMD_QUERY, 0, 0, 0, 1);
        settle();

        for (int ph = 0; ph < 6; ph++)
        begin
            configure(ph);
            idle_pct = ph < 2 ? 35 : ph < 4 ? 68 : 0;
            tpos = 0;
            random_items(30);
            settle();
        end

        for (int i = 0; i < SAMPLES + 8; i++)
            send_word(CMD_SAMPLE, 0, 16'($urandom), 0, 0);
        send_word(CMD_QUERY, 0, 0, 0, 10'h3FF);

        start <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
        if (errors == 0)
            $display("welch_t_test_leakage_accumulator: match");
        else
            $display("welch_t_test_leakage_accumulator: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
rtl/wtt_pkg.sv
rtl/wtt_ram.sv
rtl/wtt_math.sv
rtl/wtt_front.sv
rtl/wtt_back.sv
rtl/welch_t_test_leakage_accumulator.sv
rtl/wtt_checker.sv
dv/wtt_checker.sv
dv/tb_welch_t_test_leakage_accumulator.sv
